[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define LTF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// expr holds at every edge out of reset
`define LTF_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant check failed");

`endif

[hw/rtl/ltf_pkg.sv]
// ----------------------------------------------------------------------------
// ltf_pkg
// Shared constants and types of the linear toolpath follower.
// ----------------------------------------------------------------------------
package ltf_pkg;

    localparam int COORD_BITS      = 32;
    localparam int AXES            = 3;
    localparam int MAX_MOVES_DEF   = 256;
    localparam int FEED_BITS       = 31;
    localparam int TIME_BITS       = 32;
    localparam int DIFF_BITS       = COORD_BITS + 1;
    localparam int SUM_BITS        = 2 * DIFF_BITS;
    localparam int ROOT_BITS       = DIFF_BITS;
    localparam int PROD_BITS       = 64;
    localparam int INDEX_OUT_BITS  = 8;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_STEP  = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [AXES-1:0][COORD_BITS-1:0] vel;
        logic [TIME_BITS-1:0]            time_left;
        logic                            at_end;
    } ltf_result_t;

endpackage

[hw/rtl/ltf_datapath.sv]
// ----------------------------------------------------------------------------
// ltf_datapath
// Serial arithmetic: shift-add squares and products, bit-pair square root,
// restoring divider. One bit of each operation per cycle.
// ----------------------------------------------------------------------------
module ltf_datapath
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic [ltf_pkg::AXES-1:0][ltf_pkg::COORD_BITS:0] diff_abs,
    input  logic [ltf_pkg::AXES-1:0]                   diff_neg,
    input  logic [ltf_pkg::FEED_BITS-1:0]              feed,
    output logic                                       done,
    output ltf_pkg::ltf_result_t                       result
);

    localparam int DB = ltf_pkg::DIFF_BITS;
    localparam int SB = ltf_pkg::SUM_BITS;
    localparam int RB = ltf_pkg::ROOT_BITS;
    localparam int PB = ltf_pkg::PROD_BITS;
    localparam int CB = ltf_pkg::COORD_BITS;
    localparam int TB = ltf_pkg::TIME_BITS;
    localparam int FB = ltf_pkg::FEED_BITS;
    localparam int QB = RB + 3;

    typedef enum logic [2:0] {D_IDLE, D_SQ, D_SQRT, D_MUL, D_DIV, D_TDIV, D_DONE} dstate_t;

    dstate_t              state_reg;
    logic [1:0]           axis_reg;
    logic [6:0]           cnt_reg;
    logic [SB-1:0]        acc_reg;
    logic [SB-1:0]        mcand_reg;
    logic [DB-1:0]        mplier_reg;
    logic [QB-1:0]        rem_reg;
    logic [RB-1:0]        root_reg;
    logic [PB-1:0]        num_reg;
    ltf_pkg::ltf_result_t res_reg;

    logic [SB-1:0]        acc_add;
    logic [QB:0]          sq_rem;
    logic [QB:0]          sq_trial;
    logic                 sq_ge;
    logic [RB-1:0]        root_next;
    logic [RB:0]          dv_rem;
    logic [RB:0]          dv_div;
    logic                 dv_ge;
    logic [PB-1:0]        num_next;

    function automatic logic [CB-1:0] sat_vel(input logic [PB-1:0] q, input logic neg);
        logic [PB-1:0] lim;
        logic [PB-1:0] qs;
        lim = neg ? (PB'(1) << (CB - 1)) : ((PB'(1) << (CB - 1)) - PB'(1));
        qs  = (q > lim) ? lim : q;
        return neg ? (CB'(0) - qs[CB-1:0]) : qs[CB-1:0];
    endfunction

    assign acc_add   = mplier_reg[0] ? (acc_reg + mcand_reg) : acc_reg;
    assign sq_rem    = {rem_reg[QB-2:0], acc_reg[SB-1:SB-2]};
    assign sq_trial  = {2'b00, root_reg, 2'b01};
    assign sq_ge     = (sq_rem >= sq_trial);
    assign root_next = {root_reg[RB-2:0], sq_ge};
    assign dv_rem    = {rem_reg[RB-1:0], num_reg[PB-1]};
    assign dv_div    = (state_reg == D_TDIV) ? (RB+1)'(feed) : {1'b0, root_reg};
    assign dv_ge     = (dv_rem >= dv_div);
    assign num_next  = {num_reg[PB-2:0], dv_ge};

    assign done   = (state_reg == D_DONE);
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
        end
        else
        begin
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        axis_reg   <= 2'd0;
                        acc_reg    <= '0;
                        mcand_reg  <= SB'(diff_abs[0]);
                        mplier_reg <= diff_abs[0];
                        cnt_reg    <= 7'(DB - 1);
                        res_reg    <= '0;
                        state_reg  <= D_SQ;
                    end
                end
                D_SQ:
                begin
                    acc_reg    <= acc_add;
                    mcand_reg  <= {mcand_reg[SB-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[DB-1:1]};
                    cnt_reg    <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd0)
                    begin
                        if (axis_reg == 2'(ltf_pkg::AXES - 1))
                        begin
                            rem_reg   <= '0;
                            root_reg  <= '0;
                            cnt_reg   <= 7'(RB - 1);
                            state_reg <= D_SQRT;
                        end
                        else
                        begin
                            axis_reg   <= axis_reg + 2'd1;
                            mcand_reg  <= SB'(diff_abs[axis_reg + 2'd1]);
                            mplier_reg <= diff_abs[axis_reg + 2'd1];
                            cnt_reg    <= 7'(DB - 1);
                        end
                    end
                end
                D_SQRT:
                begin
                    acc_reg  <= {acc_reg[SB-3:0], 2'b00};
                    rem_reg  <= sq_ge ? QB'(sq_rem - sq_trial) : sq_rem[QB-1:0];
                    root_reg <= root_next;
                    cnt_reg  <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd0)
                    begin
                        if (root_next == '0)
                        begin
                            res_reg.at_end    <= 1'b1;
                            res_reg.time_left <= '1;
                            state_reg         <= D_DONE;
                        end
                        else
                        begin
                            axis_reg   <= 2'd0;
                            acc_reg    <= '0;
                            mcand_reg  <= SB'(diff_abs[0]);
                            mplier_reg <= DB'(feed);
                            cnt_reg    <= 7'(FB - 1);
                            state_reg  <= D_MUL;
                        end
                    end
                end
                D_MUL:
                begin
                    acc_reg    <= acc_add;
                    mcand_reg  <= {mcand_reg[SB-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[DB-1:1]};
                    cnt_reg    <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd0)
                    begin
                        num_reg   <= acc_add[PB-1:0];
                        rem_reg   <= '0;
                        cnt_reg   <= 7'(PB - 1);
                        state_reg <= D_DIV;
                    end
                end
                D_DIV:
                begin
                    rem_reg <= dv_ge ? QB'(dv_rem - dv_div) : QB'(dv_rem);
                    num_reg <= num_next;
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd0)
                    begin
                        res_reg.vel[axis_reg] <= sat_vel(num_next, diff_neg[axis_reg]);
                        if (axis_reg == 2'(ltf_pkg::AXES - 1))
                        begin
                            num_reg   <= PB'({root_reg, 16'h0000});
                            rem_reg   <= '0;
                            cnt_reg   <= 7'(PB - 1);
                            state_reg <= D_TDIV;
                        end
                        else
                        begin
                            axis_reg   <= axis_reg + 2'd1;
                            acc_reg    <= '0;
                            mcand_reg  <= SB'(diff_abs[axis_reg + 2'd1]);
                            mplier_reg <= DB'(feed);
                            cnt_reg    <= 7'(FB - 1);
                            state_reg  <= D_MUL;
                        end
                    end
                end
                D_TDIV:
                begin
                    rem_reg <= dv_ge ? QB'(dv_rem - dv_div) : QB'(dv_rem);
                    num_reg <= num_next;
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd0)
                    begin
                        res_reg.time_left <= (num_next > PB'({TB{1'b1}})) ? '1
                                                                          : num_next[TB-1:0];
                        state_reg         <= D_DONE;
                    end
                end
                D_DONE:
                begin
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/linear_toolpath_follower_core.sv]
// ----------------------------------------------------------------------------
// linear_toolpath_follower_core
// Move table with add, clear and step transactions; velocity toward the
// current end point at the move's feed, and the time left to reach it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction: action, tool
//   position, target and feed. Output channel (out_valid/out_ready) returns
//   exactly one result per input transaction, in order.
//   Add, clear, unused actions and steps on an empty table, a degenerate move
//   or zero feed: the result is set in the execute state and goes out from
//   the response state, with no math. A step that needs the math launches
//   the datapath: three serial squares, a serial square root, then per axis
//   a serial multiply and a restoring divide, a final divide for the time,
//   and the result is registered. A step that lands on the end point stops
//   after the square root. in_ready returns high once the result is loaded
//   into the output register.
//   One transaction is in flight at a time; in_ready is high when the core
//   is idle, even while a finished result waits on out_ready.
//   A stalled receiver holds the result in the output register; the core
//   then stops before loading the next result.
//   Reset empties the table and zeroes the current move; the move memories
//   are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module linear_toolpath_follower_core
#(
    parameter int MAX_MOVES = ltf_pkg::MAX_MOVES_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         action,
    input  ltf_pkg::coord_t                    tool_x,
    input  ltf_pkg::coord_t                    tool_y,
    input  ltf_pkg::coord_t                    tool_z,
    input  ltf_pkg::coord_t                    target_x,
    input  ltf_pkg::coord_t                    target_y,
    input  ltf_pkg::coord_t                    target_z,
    input  logic [ltf_pkg::FEED_BITS-1:0]      feed_rate,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ltf_pkg::coord_t                    vel_x,
    output ltf_pkg::coord_t                    vel_y,
    output ltf_pkg::coord_t                    vel_z,
    output logic [ltf_pkg::TIME_BITS-1:0]      time_to_end,
    output logic                               snapped,
    output logic                               path_done,
    output logic [ltf_pkg::INDEX_OUT_BITS-1:0] move_index,
    output logic                               status
);

    localparam int IW = (MAX_MOVES > 2) ? $clog2(MAX_MOVES) : 1;
    localparam int CW = IW + 1;
    localparam int CB = ltf_pkg::COORD_BITS;
    localparam int FB = ltf_pkg::FEED_BITS;
    localparam int AX = ltf_pkg::AXES;
    localparam int OB = ltf_pkg::INDEX_OUT_BITS;

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_LAUNCH, S_WAIT, S_RESP} state_t;

    logic [CB-1:0] mem_x [MAX_MOVES];
    logic [CB-1:0] mem_y [MAX_MOVES];
    logic [CB-1:0] mem_z [MAX_MOVES];
    logic [FB-1:0] mem_f [MAX_MOVES];
    logic          mem_d [MAX_MOVES];

    state_t                  state_reg;
    logic [CW-1:0]           mc_reg;
    logic [IW-1:0]           cur_reg;
    logic [1:0]              act_reg;
    logic [AX-1:0][CB-1:0]   tool_reg;
    logic [AX-1:0][CB-1:0]   tgt_reg;
    logic [FB-1:0]           feed_in_reg;
    logic [AX-1:0][CB-1:0]   rd_end_reg;
    logic [FB-1:0]           rd_feed_reg;
    logic                    rd_degen_reg;
    logic [AX-1:0][CB:0]     dabs_reg;
    logic [AX-1:0]           dneg_reg;
    ltf_pkg::ltf_result_t    res_reg;
    logic                    snap_reg;
    logic                    stat_reg;

    logic                    out_valid_reg;
    logic [AX-1:0][CB-1:0]   out_vel_reg;
    logic [CB-1:0]           out_time_reg;
    logic                    out_snap_reg;
    logic                    out_done_reg;
    logic [OB-1:0]           out_index_reg;
    logic                    out_stat_reg;

    logic                    accept;
    logic [IW-1:0]           rd_addr;
    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    logic [AX-1:0][CB-1:0]   start_pos;
    logic                    same_pt;
    logic [AX-1:0][CB:0]     diff;
    logic                    step_live;
    logic                    dp_start;
    logic                    dp_done;
    ltf_pkg::ltf_result_t    dp_res;
    logic [OB-1:0]           index_ext;
    logic                    table_full;
    logic                    has_next;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == S_IDLE);
    assign rd_addr    = (action == ltf_pkg::ACT_ADD) ? IW'(mc_reg - CW'(1)) : cur_reg;
    assign table_full = (mc_reg >= CW'(MAX_MOVES));
    assign wr_en      = (state_reg == S_EXEC) && (act_reg == ltf_pkg::ACT_ADD) && !table_full;
    assign wr_addr    = mc_reg[IW-1:0];
    assign step_live  = (CW'(cur_reg) < mc_reg) && !rd_degen_reg && (rd_feed_reg != '0);
    assign dp_start   = (state_reg == S_LAUNCH);
    assign has_next   = ((CW'(cur_reg) + CW'(1)) < mc_reg);

    generate
        if (IW >= OB)
        begin : g_idx_trunc
            assign index_ext = cur_reg[OB-1:0];
        end
        else
        begin : g_idx_ext
            assign index_ext = OB'(cur_reg);
        end
    endgenerate

    always_comb
    begin
        same_pt = 1'b1;
        for (int a = 0; a < AX; a++)
        begin
            start_pos[a] = (mc_reg == '0) ? tool_reg[a] : rd_end_reg[a];
            if (start_pos[a] != tgt_reg[a])
                same_pt = 1'b0;
            diff[a] = {rd_end_reg[a][CB-1], rd_end_reg[a]} - {tool_reg[a][CB-1], tool_reg[a]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= tgt_reg[0];
            mem_y[wr_addr] <= tgt_reg[1];
            mem_z[wr_addr] <= tgt_reg[2];
            mem_f[wr_addr] <= feed_in_reg;
            mem_d[wr_addr] <= same_pt;
        end
        if (accept)
        begin
            rd_end_reg[0] <= mem_x[rd_addr];
            rd_end_reg[1] <= mem_y[rd_addr];
            rd_end_reg[2] <= mem_z[rd_addr];
            rd_feed_reg   <= mem_f[rd_addr];
            rd_degen_reg  <= mem_d[rd_addr];
        end
    end

    ltf_datapath u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dp_start),
        .diff_abs (dabs_reg),
        .diff_neg (dneg_reg),
        .feed     (rd_feed_reg),
        .done     (dp_done),
        .result   (dp_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mc_reg        <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        act_reg     <= action;
                        tool_reg    <= {tool_z, tool_y, tool_x};
                        tgt_reg     <= {target_z, target_y, target_x};
                        feed_in_reg <= feed_rate;
                        state_reg   <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    res_reg.vel       <= '0;
                    res_reg.time_left <= '1;
                    res_reg.at_end    <= 1'b0;
                    snap_reg          <= 1'b0;
                    stat_reg          <= 1'b0;
                    state_reg         <= S_RESP;
                    case (act_reg)
                        ltf_pkg::ACT_ADD:
                        begin
                            if (table_full)
                                stat_reg <= 1'b1;
                            else
                                mc_reg <= mc_reg + CW'(1);
                        end
                        ltf_pkg::ACT_CLEAR:
                        begin
                            mc_reg  <= '0;
                            cur_reg <= '0;
                        end
                        ltf_pkg::ACT_STEP:
                        begin
                            if (step_live)
                            begin
                                for (int a = 0; a < AX; a++)
                                begin
                                    dneg_reg[a] <= diff[a][CB];
                                    dabs_reg[a] <= diff[a][CB] ? ((CB+1)'(0) - diff[a]) : diff[a];
                                end
                                state_reg <= S_LAUNCH;
                            end
                        end
                        default:
                        begin
                            stat_reg <= 1'b0;
                        end
                    endcase
                end
                S_LAUNCH:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (dp_done)
                    begin
                        res_reg  <= dp_res;
                        snap_reg <= dp_res.at_end;
                        if (dp_res.at_end && has_next)
                            cur_reg <= cur_reg + IW'(1);
                        state_reg <= S_RESP;
                    end
                end
                S_RESP:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_vel_reg   <= res_reg.vel;
                        out_time_reg  <= res_reg.time_left;
                        out_snap_reg  <= snap_reg;
                        out_done_reg  <= (CW'(cur_reg) >= mc_reg);
                        out_index_reg <= index_ext;
                        out_stat_reg  <= stat_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign vel_x       = out_vel_reg[0];
    assign vel_y       = out_vel_reg[1];
    assign vel_z       = out_vel_reg[2];
    assign time_to_end = out_time_reg;
    assign snapped     = out_snap_reg;
    assign path_done   = out_done_reg;
    assign move_index  = out_index_reg;
    assign status      = out_stat_reg;

    `LTF_ASSERT_ALWAYS(a_count_bound, clk, rst_n, mc_reg <= CW'(MAX_MOVES))
    `LTF_ASSERT_ALWAYS(a_cur_in_table, clk, rst_n, (CW'(cur_reg) < mc_reg) || (cur_reg == '0))
    `LTF_ASSERT_IMPLIES(a_snap_idle, clk, rst_n, out_valid_reg && out_snap_reg, (out_vel_reg == '0) && (out_time_reg == '1))

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench of linear_toolpath_follower_core: it drives add, clear, step and
// unused transactions with random idling and stalls on both sides, predicts
// every result from its own model of the move table, and compares each result
// field by field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int TABLE_DEPTH = ltf_pkg::MAX_MOVES_DEF;

    typedef struct {
        logic [1:0]         act;
        logic signed [31:0] tx, ty, tz;
        logic signed [31:0] gx, gy, gz;
        logic [30:0]        feed;
    } move_txn_t;

    typedef struct {
        logic [31:0] vx, vy, vz, tl;
        logic        snp, done;
        logic [7:0]  idx;
        logic        st;
    } motion_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] action = '0;
    ltf_pkg::coord_t tool_x = '0, tool_y = '0, tool_z = '0;
    ltf_pkg::coord_t target_x = '0, target_y = '0, target_z = '0;
    logic [ltf_pkg::FEED_BITS-1:0] feed_rate = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    ltf_pkg::coord_t vel_x, vel_y, vel_z;
    logic [ltf_pkg::TIME_BITS-1:0] time_to_end;
    logic snapped, path_done, status;
    logic [ltf_pkg::INDEX_OUT_BITS-1:0] move_index;

    // shadow move table
    logic signed [31:0] end_x [TABLE_DEPTH];
    logic signed [31:0] end_y [TABLE_DEPTH];
    logic signed [31:0] end_z [TABLE_DEPTH];
    logic [30:0]        feed_tbl [TABLE_DEPTH];
    bit                 degen_tbl [TABLE_DEPTH];
    int unsigned        move_cnt = 0;
    int unsigned        cur_move = 0;

    motion_res_t expected_q[$];
    int  errors = 0;
    int  items_sent = 0;
    bit  quiet = 1'b0;
    int  hold_cycles = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    linear_toolpath_follower_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action),
        .tool_x(tool_x), .tool_y(tool_y), .tool_z(tool_z),
        .target_x(target_x), .target_y(target_y), .target_z(target_z),
        .feed_rate(feed_rate),
        .out_valid(out_valid), .out_ready(out_ready),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
        .time_to_end(time_to_end), .snapped(snapped), .path_done(path_done),
        .move_index(move_index), .status(status)
    );

    function automatic logic [31:0] axis_vel(logic signed [33:0] d, logic [30:0] f,
                                             logic [127:0] r);
        logic [33:0]  mag;
        logic [127:0] q;
        logic [127:0] lim;
        mag = d[33] ? -d : d;
        q = ({94'd0, mag} * {97'd0, f}) / r;
        lim = d[33] ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim)
            q = lim;
        return d[33] ? -q[31:0] : q[31:0];
    endfunction

    function automatic motion_res_t predict_motion(move_txn_t t);
        motion_res_t res;
        logic signed [33:0] dx, dy, dz;
        logic [33:0] ax, ay, az;
        logic [127:0] sum, rt, cand, tq;
        logic signed [31:0] sx, sy, sz;
        res = '{32'd0, 32'd0, 32'd0, 32'hffff_ffff, 1'b0, 1'b0, 8'd0, 1'b0};
        if (t.act == ltf_pkg::ACT_ADD) begin
            if (move_cnt >= TABLE_DEPTH)
                res.st = 1'b1;
            else begin
                if (move_cnt == 0) begin
                    sx = t.tx; sy = t.ty; sz = t.tz;
                end else begin
                    sx = end_x[move_cnt-1]; sy = end_y[move_cnt-1]; sz = end_z[move_cnt-1];
                end
                end_x[move_cnt] = t.gx;
                end_y[move_cnt] = t.gy;
                end_z[move_cnt] = t.gz;
                feed_tbl[move_cnt] = t.feed;
                degen_tbl[move_cnt] = (sx == t.gx) && (sy == t.gy) && (sz == t.gz);
                move_cnt++;
            end
        end else if (t.act == ltf_pkg::ACT_CLEAR) begin
            move_cnt = 0;
            cur_move = 0;
        end else if (t.act == ltf_pkg::ACT_STEP && cur_move < move_cnt) begin
            if (!degen_tbl[cur_move] && feed_tbl[cur_move] != 0) begin
                dx = end_x[cur_move] - t.tx;
                dy = end_y[cur_move] - t.ty;
                dz = end_z[cur_move] - t.tz;
                ax = dx[33] ? -dx : dx;
                ay = dy[33] ? -dy : dy;
                az = dz[33] ? -dz : dz;
                sum = ({94'd0, ax} * {94'd0, ax}) + ({94'd0, ay} * {94'd0, ay})
                    + ({94'd0, az} * {94'd0, az});
                rt = '0;
                for (int b = 35; b >= 0; b--) begin
                    cand = rt | (128'd1 << b);
                    if (cand * cand <= sum)
                        rt = cand;
                end
                if (rt == 0) begin
                    res.snp = 1'b1;
                    if (cur_move + 1 < move_cnt)
                        cur_move++;
                end else begin
                    res.vx = axis_vel(dx, feed_tbl[cur_move], rt);
                    res.vy = axis_vel(dy, feed_tbl[cur_move], rt);
                    res.vz = axis_vel(dz, feed_tbl[cur_move], rt);
                    tq = (rt << 16) / {97'd0, feed_tbl[cur_move]};
                    res.tl = (tq > 128'hffff_ffff) ? 32'hffff_ffff : tq[31:0];
                end
            end
        end
        res.done = (cur_move >= move_cnt);
        res.idx = cur_move[7:0];
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] exp);
        $display("ERROR %0t %s: got %h expected %h", $realtime, what, got, exp);
        errors++;
    endtask

    task automatic send_txn(move_txn_t t);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        in_valid = 1'b1;
        action = t.act;
        tool_x = t.tx; tool_y = t.ty; tool_z = t.tz;
        target_x = t.gx; target_y = t.gy; target_z = t.gz;
        feed_rate = t.feed;
        do @(posedge clk); while (!in_ready);
        expected_q.insert(expected_q.size(), predict_motion(t));
        items_sent++;
    endtask

    function automatic move_txn_t mk(logic [1:0] a, logic signed [31:0] tx,
                                     logic signed [31:0] ty, logic signed [31:0] tz,
                                     logic signed [31:0] gx, logic signed [31:0] gy,
                                     logic signed [31:0] gz, logic [30:0] f);
        move_txn_t t;
        t = '{a, tx, ty, tz, gx, gy, gz, f};
        return t;
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        wait (expected_q.size() == 0);
    endtask

    // receiver: random stall per result, plus long holds on request
    initial begin
        int stall;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                out_ready = 1'b0;
                while (hold_cycles > 0) begin
                    @(negedge clk);
                    hold_cycles--;
                end
            end
            stall = quiet ? 0 : $urandom_range(0, 12);
            out_ready = 1'b0;
            repeat (stall) @(negedge clk);
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk) begin
        motion_res_t e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0)
                report("unexpected transaction", 32'd0, 32'd0);
            else begin
                e = expected_q.pop_front();
                if (vel_x !== e.vx) report("vel_x", vel_x, e.vx);
                if (vel_y !== e.vy) report("vel_y", vel_y, e.vy);
                if (vel_z !== e.vz) report("vel_z", vel_z, e.vz);
                if (time_to_end !== e.tl) report("time_to_end", time_to_end, e.tl);
                if (snapped !== e.snp) report("snapped", 32'(snapped), 32'(e.snp));
                if (path_done !== e.done) report("path_done", 32'(path_done), 32'(e.done));
                if (move_index !== e.idx) report("move_index", 32'(move_index), 32'(e.idx));
                if (status !== e.st) report("status", 32'(status), 32'(e.st));
            end
        end
    end

    task automatic test_idle_actions();
        send_txn(mk(ltf_pkg::ACT_STEP, 0, 0, 0, 0, 0, 0, 31'd0));
        send_txn(mk(ACT_NONE, '1, '1, '1, '1, '1, '1, '1));
        send_txn(mk(ltf_pkg::ACT_CLEAR, 32'sh8000_0000, 1, 2, 3, 4, 5, 31'd6));
        send_txn(mk(ltf_pkg::ACT_STEP, 32'sh7fff_ffff, 0, 0, 0, 0, 0, '1));
    endtask

    task automatic test_directed_moves();
        // first move starts at the tool position; snap advances to next move
        send_txn(mk(ltf_pkg::ACT_ADD, 0, 0, 0, 32'sh000a_0000, 0, 0, 31'h0001_0000));
        send_txn(mk(ltf_pkg::ACT_ADD, 0, 0, 0, 32'sh000a_0000, 32'sh0005_0000, 0,
                    31'h0002_0000));
        send_txn(mk(ltf_pkg::ACT_ADD, 0, 0, 0, 32'sh000a_0000, 32'sh0005_0000, 0,
                    31'h0002_0000));
        send_txn(mk(ltf_pkg::ACT_ADD, 0, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000,
                    32'sh7fff_ffff, '1));
        send_txn(mk(ltf_pkg::ACT_ADD, 0, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff, 0, 31'd0));
        send_txn(mk(ltf_pkg::ACT_ADD, 0, 0, 0, 1, 1, 1, 31'd1));
        send_txn(mk(ltf_pkg::ACT_STEP, 0, 0, 0, 0, 0, 0, 31'd0));
        send_txn(mk(ltf_pkg::ACT_STEP, 32'sh000a_0000, 0, 0, 0, 0, 0, 31'd0));
        send_txn(mk(ltf_pkg::ACT_STEP, 32'sh000a_0000, 0, 0, 0, 0, 0, 31'd0));
        send_txn(mk(ltf_pkg::ACT_STEP, 32'sh000a_0000, 32'sh0005_0000, 0, 0, 0, 0, 31'd0));
        send_txn(mk(ltf_pkg::ACT_STEP, 32'sh000a_0000, 32'sh0005_0000, 0, 0, 0, 0, 31'd0));
        send_txn(mk(ltf_pkg::ACT_STEP, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                    0, 0, 0, 31'd0));
        send_txn(mk(ltf_pkg::ACT_STEP, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                    0, 0, 0, 31'd0));
        send_txn(mk(ltf_pkg::ACT_STEP, 0, 0, 0, 0, 0, 0, 31'd0));
        send_txn(mk(ltf_pkg::ACT_STEP, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 0, 0, 31'd0));
        send_txn(mk(ltf_pkg::ACT_STEP, 1, 1, 1, 0, 0, 0, 31'd0));
        send_txn(mk(ltf_pkg::ACT_STEP, 1, 1, 1, 0, 0, 0, 31'd0));
        send_txn(mk(ltf_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 31'd0));
        send_txn(mk(ltf_pkg::ACT_ADD, 5, 5, 5, 5, 5, 5, 31'h100));
        send_txn(mk(ltf_pkg::ACT_STEP, 5, 5, 5, 0, 0, 0, 31'd0));
    endtask

    task automatic test_full_table();
        quiet = 1'b1;
        send_txn(mk(ltf_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 31'd0));
        for (int i = 0; i <= TABLE_DEPTH; i++)
            send_txn(mk(ltf_pkg::ACT_ADD, 0, 0, 0, i + 1, -i, i * 7, 31'(i)));
        send_txn(mk(ltf_pkg::ACT_STEP, 3, 0, 0, 0, 0, 0, 31'd0));
        quiet = 1'b0;
    endtask

    function automatic logic signed [31:0] rnd_coord();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $signed($urandom) >>> $urandom_range(8, 31);
    endfunction

    function automatic logic [30:0] rnd_feed();
        if ($urandom_range(0, 19) == 0)
            return 31'd0;
        return 31'($urandom) >> $urandom_range(0, 30);
    endfunction

    task automatic run_sequence();
        move_txn_t t;
        int n;
        logic signed [31:0] px, py, pz;
        if ($urandom_range(0, 2) == 0)
            send_txn(mk(ltf_pkg::ACT_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(),
                        rnd_coord(), rnd_coord(), rnd_coord(), rnd_feed()));
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
            t = mk(ltf_pkg::ACT_ADD, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                   rnd_coord(), rnd_coord(), rnd_feed());
            if ($urandom_range(0, 9) == 0) begin
                if (move_cnt == 0) begin
                    t.gx = t.tx; t.gy = t.ty; t.gz = t.tz;
                end else if (move_cnt <= TABLE_DEPTH) begin
                    t.gx = end_x[move_cnt-1]; t.gy = end_y[move_cnt-1];
                    t.gz = end_z[move_cnt-1];
                end
            end
            send_txn(t);
        end
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            t = mk(ltf_pkg::ACT_STEP, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                   rnd_coord(), rnd_coord(), rnd_feed());
            if (cur_move < move_cnt && $urandom_range(0, 9) < 8) begin
                px = end_x[cur_move]; py = end_y[cur_move]; pz = end_z[cur_move];
                if ($urandom_range(0, 2) != 0) begin
                    px = px + ($signed($urandom) >>> $urandom_range(10, 31));
                    py = py + ($signed($urandom) >>> $urandom_range(10, 31));
                    pz = pz + ($signed($urandom) >>> $urandom_range(10, 31));
                end
                t.tx = px; t.ty = py; t.tz = pz;
            end
            send_txn(t);
        end
        if ($urandom_range(0, 19) == 0)
            send_txn(mk(ACT_NONE, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                        rnd_coord(), rnd_coord(), rnd_feed()));
    endtask

    task automatic test_random();
        while (items_sent < 1200) begin
            quiet = ($urandom_range(0, 4) == 0);
            run_sequence();
        end
        quiet = 1'b0;
    endtask

    task automatic test_pressure();
        hold_cycles = 2000;
        for (int i = 0; i < 4; i++)
            send_txn(mk(ltf_pkg::ACT_ADD, 0, 0, 0, rnd_coord(), rnd_coord(), rnd_coord(),
                        rnd_feed()));
        wait_drained();
        for (int i = 0; i < 4; i++)
            send_txn(mk(ltf_pkg::ACT_STEP, rnd_coord(), rnd_coord(), rnd_coord(),
                        0, 0, 0, 31'd0));
    endtask

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_idle_actions();
        test_directed_moves();
        test_full_table();
        test_pressure();
        test_random();
        wait_drained();
        repeat (600) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #80_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
